// ----- rtl/order_book_sweep_cost_defines.svh -----
// Assertion macros shared by the order book RTL.
// Include with the bare file name; no other dependencies.
`ifndef ORDER_BOOK_SWEEP_COST_DEFINES_SVH
`define ORDER_BOOK_SWEEP_COST_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, disabled during reset
`define OBSC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("obsc assertion failed");

// Next-cycle implication, sampled on clk_i, disabled during reset
`define OBSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("obsc assertion failed");

`endif

// ----- rtl/obsc_pkg.sv -----
// Shared types, codes and helpers for the order book sweep cost block.
// No dependencies.
package obsc_pkg;

  localparam int unsigned PRICE_W = 32;
  localparam int unsigned QTY_W   = 24;
  localparam int unsigned COST_W  = 56;
  localparam int unsigned LIQ_W   = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_INS_BID = 2'd1,
    CMD_INS_ASK = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SHORT_BUY  = 2'd1,
    ST_SHORT_SELL = 2'd2,
    ST_BOOK_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_SWEEP  = 2'd2
  } book_op_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [PRICE_W-1:0] entry_price;
    logic [QTY_W-1:0]   entry_quantity;
    logic [QTY_W-1:0]   request_quantity;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [COST_W-1:0] buy_cost;
    logic [COST_W-1:0] sell_cost;
    logic [LIQ_W-1:0]  ask_liquidity;
    logic [LIQ_W-1:0]  bid_liquidity;
  } out_t;

  // One price level as stored in a book memory
  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } level_t;

  // Request from the top sequencer to one book
  typedef struct packed {
    logic     start;
    book_op_e op;
  } book_cmd_t;

  // Book status back to the top sequencer
  typedef struct packed {
    logic busy;
    logic full;
  } book_stat_t;

  // Clamp an exact liquidity sum to the 32-bit output range
  function automatic logic [LIQ_W-1:0] sat_liq(input logic [39:0] v);
    logic [LIQ_W-1:0] r;
    r = (v > 40'hFFFF_FFFF) ? {LIQ_W{1'b1}} : v[LIQ_W-1:0];
    return r;
  endfunction

endpackage

// ----- rtl/obsc_book.sv -----
// One price-sorted book: level memory, sorted insert and fill-cost sweep.
// Depends on obsc_pkg and order_book_sweep_cost_defines.svh.
`include "order_book_sweep_cost_defines.svh"
module obsc_book import obsc_pkg::*; #(
  parameter int unsigned Depth   = 256,
  parameter bit          Descend = 1'b0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  book_cmd_t                            cmd_i,
  input  logic [PRICE_W-1:0]                   price_i,
  input  logic [QTY_W-1:0]                     qty_i,
  input  logic [QTY_W-1:0]                     request_i,
  output book_stat_t                           stat_o,
  output logic [COST_W-1:0]                    cost_o,
  output logic [QTY_W+$clog2(Depth+1)-1:0]     total_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned TW = QTY_W + CW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_WR,
    S_SW_RD,
    S_SW_MUL
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      count_q;
  logic [TW-1:0]      total_q;
  logic               full_q;
  logic [CW-1:0]      pos_q;
  logic [CW-1:0]      k_q;
  logic [QTY_W-1:0]   rem_q;
  logic [COST_W-1:0]  cost_q;
  logic [COST_W-1:0]  prod_q;
  logic               acc_pend_q;
  level_t             new_q;

  level_t             mem_q [Depth];
  level_t             rd_data_q;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  level_t             wr_data;
  logic [QTY_W-1:0]   fill;
  logic [CW-1:0]      sweep_idx;

  // Pick the level index for the current sweep step
  assign sweep_idx = Descend ? (count_q - CW'(1) - k_q) : k_q;
  assign fill      = (rem_q < rd_data_q.qty) ? rem_q : rd_data_q.qty;

  // Drive the read and write ports
  always_comb begin
    rd_addr = AW'(pos_q - CW'(1));
    wr_en   = 1'b0;
    wr_addr = AW'(pos_q);
    wr_data = new_q;
    case (state_q)
      S_INS_RD: rd_addr = AW'(pos_q - CW'(1));
      S_INS_CMP: begin
        rd_addr = AW'(pos_q - CW'(2));
        wr_en   = 1'b1;
        if (rd_data_q.price > new_q.price) begin
          wr_data = rd_data_q;
        end
      end
      S_INS_WR: wr_en = 1'b1;
      S_SW_RD: rd_addr = AW'(sweep_idx);
      default: ;
    endcase
  end

  // Level memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      total_q    <= '0;
      full_q     <= 1'b0;
      pos_q      <= '0;
      k_q        <= '0;
      rem_q      <= '0;
      cost_q     <= '0;
      prod_q     <= '0;
      acc_pend_q <= 1'b0;
      new_q      <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_i.start) begin
            case (cmd_i.op)
              OP_CLEAR: begin
                count_q <= '0;
                total_q <= '0;
                full_q  <= 1'b0;
              end
              OP_INSERT: begin
                new_q.price <= price_i;
                new_q.qty   <= qty_i;
                pos_q       <= count_q;
                if (count_q == CW'(Depth)) begin
                  full_q <= 1'b1;
                end else begin
                  full_q  <= 1'b0;
                  state_q <= (count_q == '0) ? S_INS_WR : S_INS_RD;
                end
              end
              OP_SWEEP: begin
                rem_q      <= request_i;
                k_q        <= '0;
                cost_q     <= '0;
                acc_pend_q <= 1'b0;
                state_q    <= S_SW_RD;
              end
              default: ;
            endcase
          end
        end
        S_INS_RD: state_q <= S_INS_CMP;
        S_INS_CMP: begin
          if (rd_data_q.price > new_q.price) begin
            // shift this level up one slot and keep walking down
            pos_q <= pos_q - CW'(1);
            if (pos_q == CW'(1)) begin
              state_q <= S_INS_WR;
            end
          end else begin
            count_q <= count_q + CW'(1);
            total_q <= total_q + TW'(new_q.qty);
            state_q <= S_IDLE;
          end
        end
        S_INS_WR: begin
          count_q <= count_q + CW'(1);
          total_q <= total_q + TW'(new_q.qty);
          state_q <= S_IDLE;
        end
        S_SW_RD: begin
          // fold in the previous product, then stop or fetch next level
          if (acc_pend_q) begin
            cost_q <= cost_q + prod_q;
          end
          acc_pend_q <= 1'b0;
          if (rem_q == '0 || k_q == count_q) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_SW_MUL;
          end
        end
        S_SW_MUL: begin
          prod_q     <= COST_W'(fill) * COST_W'(rd_data_q.price);
          rem_q      <= rem_q - fill;
          k_q        <= k_q + CW'(1);
          acc_pend_q <= 1'b1;
          state_q    <= S_SW_RD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.full = full_q;
  assign cost_o      = cost_q;
  assign total_o     = total_q;

  `OBSC_ASSERT_IMPL(a_count_range, 1'b1, count_q <= CW'(Depth))
  `OBSC_ASSERT_NEXT(a_rem_falls, state_q == S_SW_MUL, rem_q <= $past(rem_q))
  `OBSC_ASSERT_NEXT(a_full_keeps_count,
                    state_q == S_IDLE && cmd_i.start && cmd_i.op == OP_INSERT
                      && count_q == CW'(Depth),
                    count_q == $past(count_q) && state_q == S_IDLE)

endmodule

// ----- rtl/order_book_sweep_cost.sv -----
// Top level: command sequencer over the ask and bid books, output register.
// Depends on obsc_pkg, obsc_book and order_book_sweep_cost_defines.svh.
//
//  channel | dir | handshake              | payload
//  in      | in  | in_valid_i/in_ready_o  | in_data_i  (in_t)
//  out     | out | out_valid_o/out_ready_i| out_data_o (out_t)
//
// A beat goes from accept through T_WAIT, until both books are idle, and
// T_DONE, until the output slot frees, back to ready. A clear, full-book
// insert or short query starts no book work; an insert shifts each higher
// level up one slot, one read and one write a cycle; a query sweeps levels.
// Reset empties both books at once; no clearing pass is needed.
// A result waiting on out_ready_i holds the next one back but not its work.
`include "order_book_sweep_cost_defines.svh"
module order_book_sweep_cost import obsc_pkg::*; #(
  parameter int unsigned BOOK_DEPTH = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned TW = QTY_W + $clog2(BOOK_DEPTH + 1);

  typedef enum logic [1:0] {
    T_IDLE,
    T_WAIT,
    T_DONE
  } tstate_e;

  tstate_e          state_q;
  logic [1:0]       cmd_q;
  logic [1:0]       status_q;
  logic             out_valid_q;
  out_t             out_q;
  book_cmd_t        ask_cmd;
  book_cmd_t        bid_cmd;
  book_stat_t       ask_stat;
  book_stat_t       bid_stat;
  logic [COST_W-1:0] ask_cost;
  logic [COST_W-1:0] bid_cost;
  logic [TW-1:0]    ask_total;
  logic [TW-1:0]    bid_total;
  logic             in_fire;
  logic             short_buy;
  logic             short_sell;
  logic             do_sweep;
  logic             slot_free;
  logic [1:0]       res_status;
  logic [1:0]       in_status;
  logic             sweep_ok;

  assign in_ready_o = (state_q == T_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // Liquidity check ahead of a sweep
  assign short_buy  = 40'(in_data_i.request_quantity) > 40'(ask_total);
  assign short_sell = 40'(in_data_i.request_quantity) > 40'(bid_total);
  assign do_sweep   = (in_data_i.command == CMD_QUERY) && !short_buy && !short_sell;

  // Status of a query known at accept time
  always_comb begin
    in_status = ST_OK;
    if (in_data_i.command == CMD_QUERY) begin
      if (short_buy) begin
        in_status = ST_SHORT_BUY;
      end else if (short_sell) begin
        in_status = ST_SHORT_SELL;
      end
    end
  end

  // Launch book work on the accepted beat
  always_comb begin
    ask_cmd = '{start: 1'b0, op: OP_CLEAR};
    bid_cmd = '{start: 1'b0, op: OP_CLEAR};
    if (in_fire) begin
      case (in_data_i.command)
        CMD_CLEAR: begin
          ask_cmd = '{start: 1'b1, op: OP_CLEAR};
          bid_cmd = '{start: 1'b1, op: OP_CLEAR};
        end
        CMD_INS_BID: bid_cmd = '{start: 1'b1, op: OP_INSERT};
        CMD_INS_ASK: ask_cmd = '{start: 1'b1, op: OP_INSERT};
        CMD_QUERY: begin
          if (do_sweep) begin
            ask_cmd = '{start: 1'b1, op: OP_SWEEP};
            bid_cmd = '{start: 1'b1, op: OP_SWEEP};
          end
        end
        default: ;
      endcase
    end
  end

  obsc_book #(.Depth(BOOK_DEPTH), .Descend(1'b0)) u_ask (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (ask_cmd),
    .price_i   (in_data_i.entry_price),
    .qty_i     (in_data_i.entry_quantity),
    .request_i (in_data_i.request_quantity),
    .stat_o    (ask_stat),
    .cost_o    (ask_cost),
    .total_o   (ask_total)
  );

  obsc_book #(.Depth(BOOK_DEPTH), .Descend(1'b1)) u_bid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (bid_cmd),
    .price_i   (in_data_i.entry_price),
    .qty_i     (in_data_i.entry_quantity),
    .request_i (in_data_i.request_quantity),
    .stat_o    (bid_stat),
    .cost_o    (bid_cost),
    .total_o   (bid_total)
  );

  // Final status of the held command
  always_comb begin
    res_status = status_q;
    case (cmd_q)
      CMD_INS_BID: res_status = bid_stat.full ? ST_BOOK_FULL : ST_OK;
      CMD_INS_ASK: res_status = ask_stat.full ? ST_BOOK_FULL : ST_OK;
      default: ;
    endcase
  end

  assign sweep_ok = (cmd_q == CMD_QUERY) && (status_q == ST_OK);

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      cmd_q       <= CMD_CLEAR;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Load a result beat when the slot frees, drop it once taken
      if (state_q == T_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        T_IDLE: begin
          if (in_fire) begin
            cmd_q    <= in_data_i.command;
            status_q <= in_status;
            state_q  <= T_WAIT;
          end
        end
        T_WAIT: begin
          if (!ask_stat.busy && !bid_stat.busy) begin
            state_q <= T_DONE;
          end
        end
        T_DONE: begin
          if (slot_free) begin
            out_q.status         <= res_status;
            out_q.buy_cost       <= sweep_ok ? ask_cost : '0;
            out_q.sell_cost      <= sweep_ok ? bid_cost : '0;
            out_q.ask_liquidity  <= sat_liq(40'(ask_total));
            out_q.bid_liquidity  <= sat_liq(40'(bid_total));
            state_q <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `OBSC_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready_o)
  `OBSC_ASSERT_IMPL(a_short_zero_cost,
                    out_valid_o && (out_data_o.status == ST_SHORT_BUY
                      || out_data_o.status == ST_SHORT_SELL),
                    out_data_o.buy_cost == '0 && out_data_o.sell_cost == '0)
  `OBSC_ASSERT_IMPL(a_books_idle_when_ready, in_ready_o, !ask_stat.busy && !bid_stat.busy)

endmodule
